@@ rtl/atoib_pkg.sv @@
package atoib_pkg;

    // field and register widths
    localparam int CH_W        = 8;
    localparam int VALUE_W     = 32;
    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_IDX_W   = 4;
    localparam int LEN_W       = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int REG_IDX_W   = 2;

    // register indexes, byte address is 8 * index
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_LEN  = 2'd2;

    // character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_SIGN   = 4'b0001,
        PH_SPACE  = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    // configuration seen by the parser
    typedef struct packed {
        logic [CFG_DATA_W-1:0] alpha_low;
        logic [CFG_DATA_W-1:0] alpha_high;
        logic [LEN_W-1:0]      alpha_len;
        logic                  base_valid;
    } cfg_t;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_sign(input logic [CH_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // symbol i of the alphabet, low word holds symbols 0..7
    function automatic logic [CH_W-1:0] sym_at(input logic [CFG_DATA_W-1:0] lo,
                                               input logic [CFG_DATA_W-1:0] hi,
                                               input logic [SYM_IDX_W-1:0] i);
        logic [CFG_DATA_W-1:0] word;
        word = i[SYM_IDX_W-1] ? hi : lo;
        return word[i[SYM_IDX_W-2:0]*CH_W +: CH_W];
    endfunction

endpackage

@@ rtl/atoib_cfg.sv @@
module atoib_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [atoib_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [atoib_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [atoib_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output atoib_pkg::cfg_t                  cfg
);
    import atoib_pkg::*;

    logic [CFG_DATA_W-1:0] alpha_low_reg;
    logic [CFG_DATA_W-1:0] alpha_high_reg;
    logic [LEN_W-1:0]      alpha_len_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;
    logic [CH_W-1:0]       sym [MAX_SYMBOLS];
    logic                  base_ok;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_len_reg  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                REG_ALPHA_LEN:  alpha_len_reg  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            REG_ALPHA_LEN:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, alpha_len_reg};
            default:        prdata = '0;
        endcase
    end

    // unpack symbols
    always_comb begin
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            sym[i] = sym_at(alpha_low_reg, alpha_high_reg, SYM_IDX_W'(i));
        end
    end

    // base check: length in range, no sign symbol, no repeated symbol
    always_comb begin
        base_ok = (alpha_len_reg >= LEN_W'(2)) && (alpha_len_reg <= LEN_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (LEN_W'(i) < alpha_len_reg) begin
                if (is_sign(sym[i])) begin
                    base_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if ((LEN_W'(j) < alpha_len_reg) && (sym[j] == sym[i])) begin
                        base_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign cfg.alpha_low  = alpha_low_reg;
    assign cfg.alpha_high = alpha_high_reg;
    assign cfg.alpha_len  = alpha_len_reg;
    assign cfg.base_valid = base_ok;

endmodule

@@ rtl/atoib_parse.sv @@
module atoib_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [atoib_pkg::CH_W-1:0]    ch,
    input  logic                          last,
    input  atoib_pkg::cfg_t               cfg,
    output logic [atoib_pkg::VALUE_W-1:0] res_value,
    output logic                          res_base_valid
);
    import atoib_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic [LEN_W-1:0]     n_eff;
    logic                 hit;
    logic [SYM_IDX_W-1:0] hit_idx;
    logic [VALUE_W+LEN_W-1:0] prod;
    logic [VALUE_W-1:0]   acc_digit;
    phase_t               digit_phase;
    logic [VALUE_W-1:0]   digit_acc;
    logic [VALUE_W-1:0]   signed_acc;

    assign n_eff = (cfg.alpha_len > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS)
                                                           : cfg.alpha_len;

    // parallel symbol compare, lowest index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((LEN_W'(i) < n_eff) &&
                (sym_at(cfg.alpha_low, cfg.alpha_high, SYM_IDX_W'(i)) == ch)) begin
                hit     = 1'b1;
                hit_idx = SYM_IDX_W'(i);
            end
        end
    end

    // multiply-accumulate, wraps at value width
    assign prod      = {{LEN_W{1'b0}}, acc_reg} * {{VALUE_W{1'b0}}, n_eff};
    assign acc_digit = prod[VALUE_W-1:0] + {{(VALUE_W-SYM_IDX_W){1'b0}}, hit_idx};

    // digit handling: sign or space stops, unknown clears and stops
    always_comb begin
        if (is_sign(ch) || is_space(ch)) begin
            digit_phase = PH_STOP;
            digit_acc   = acc_reg;
        end else if (hit) begin
            digit_phase = PH_DIGITS;
            digit_acc   = acc_digit;
        end else begin
            digit_phase = PH_STOP;
            digit_acc   = '0;
        end
    end

    // phase sequencing for one character
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        if (ch == CH_NUL) begin
            if (phase_reg != PH_STOP) begin
                phase_next = PH_STOP;
            end
        end else begin
            case (phase_reg)
                PH_SIGN: begin
                    if (is_sign(ch)) begin
                        neg_next   = (ch == CH_MINUS);
                        phase_next = PH_SPACE;
                    end else if (is_space(ch)) begin
                        phase_next = PH_SPACE;
                    end else begin
                        phase_next = digit_phase;
                        acc_next   = digit_acc;
                    end
                end
                PH_SPACE: begin
                    if (!is_space(ch)) begin
                        phase_next = digit_phase;
                        acc_next   = digit_acc;
                    end
                end
                PH_DIGITS: begin
                    phase_next = digit_phase;
                    acc_next   = digit_acc;
                end
                PH_STOP: ;
                default: phase_next = PH_STOP;
            endcase
        end
    end

    // result from the state after this character
    assign signed_acc     = neg_next ? (VALUE_W'(0) - acc_next) : acc_next;
    assign res_value      = cfg.base_valid ? signed_acc : '0;
    assign res_base_valid = cfg.base_valid;

    // parser state, back to start after the last character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIGN;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
        end else if (step) begin
            if (last) begin
                phase_reg <= PH_SIGN;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
            end
        end
    end

endmodule

@@ rtl/text_to_integer_any_base.sv @@
// result path: the tlast character passes the input register, then the result register, before m_tvalid rises
// throughput: one character per cycle; the parser state loop accepts a character on every step
// a result transaction that waits at the output only stalls the input on a tlast character
// reset: synchronous, active low; clears the alphabet registers, the parser state
// and both pipeline registers
module text_to_integer_any_base (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [atoib_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [atoib_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [atoib_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    // character stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // ch[7:0]
    input  logic                             s_tlast,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,  // value[31:0]
    output logic                             m_tuser   // base_valid
);
    import atoib_pkg::*;

    cfg_t                 cfg;
    logic                 in_valid_reg;
    logic [CH_W-1:0]      in_ch_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_base_valid_reg;
    logic                 out_free;
    logic                 step;
    logic [VALUE_W-1:0]   res_value;
    logic                 res_base_valid;

    atoib_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: a character moves on unless it needs a busy output slot
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata[CH_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    atoib_parse u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .ch             (in_ch_reg),
        .last           (in_last_reg),
        .cfg            (cfg),
        .res_value      (res_value),
        .res_base_valid (res_base_valid)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_value_reg      <= res_value;
            out_base_valid_reg <= res_base_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_base_valid_reg;

    // reset empties both pipeline registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // a finished string always lands in the result register
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last_reg |=> out_valid_reg)
        else $error("result lost for last character");

    // a stalled character stays in the input register
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_ch_reg) && $stable(in_last_reg))
        else $error("stalled character dropped");

    // an invalid base gives value zero
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_base_valid_reg |-> out_value_reg == '0)
        else $error("nonzero value for invalid base");

    // the result slot is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(step && in_last_reg))
        else $error("waiting result overwritten");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import atoib_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int CHUNK_CHARS = 150;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic            last;
    } char_item_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               base_valid;
    } parse_result_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tuser;

    // characters waiting to be sent and parse results still due
    char_item_t    pending_chars[$];
    parse_result_t expected_parses[$];
    char_item_t    next_char;
    parse_result_t due;
    logic [CH_W-1:0] alpha_syms[$];
    int            queued_count = 0;
    int            errors       = 0;
    int            send_idle    = 23;
    int            recv_idle    = 48;
    int            stall_cycles = 0;
    logic          s_taken      = 1'b0;

    // shadow of the alphabet registers
    logic [CFG_DATA_W-1:0] alpha_lo_m  = '0;
    logic [CFG_DATA_W-1:0] alpha_hi_m  = '0;
    logic [LEN_W-1:0]      alpha_len_m = '0;

    // parser state of the predictor
    phase_t             prs_phase = PH_SIGN;
    logic [VALUE_W-1:0] prs_acc   = '0;
    logic               prs_neg   = 1'b0;

    text_to_integer_any_base u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic blank_char(input logic [CH_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
               c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic sign_char(input logic [CH_W-1:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic [CH_W-1:0] symbol(input int i);
        logic [CFG_DATA_W-1:0] w;
        w = (i >= 8) ? alpha_hi_m : alpha_lo_m;
        return w[(i % 8) * 8 +: 8];
    endfunction

    // base needs 2..16 distinct symbols and no sign among them
    function automatic logic alphabet_ok();
        int   n;
        logic ok;
        n  = alpha_len_m;
        ok = (n >= 2) && (n <= MAX_SYMBOLS);
        if (ok) begin
            for (int i = 0; i < n; i++) begin
                if (sign_char(symbol(i)))
                    ok = 1'b0;
                for (int j = i + 1; j < n; j++)
                    if (symbol(j) == symbol(i))
                        ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // digit lookup: sign or blank stops, unknown clears and stops
    task automatic take_digit(input logic [CH_W-1:0] c);
        int   n;
        logic hit;
        hit = 1'b0;
        n   = (alpha_len_m > 16) ? 16 : alpha_len_m;
        if (sign_char(c) || blank_char(c)) begin
            prs_phase = PH_STOP;
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!hit && symbol(i) == c) begin
                    prs_acc = prs_acc * n + i;
                    hit     = 1'b1;
                end
            end
            if (hit) begin
                prs_phase = PH_DIGITS;
            end else begin
                prs_acc   = '0;
                prs_phase = PH_STOP;
            end
        end
    endtask

    // advance the parser by one character, queue a result on the last one
    task automatic parse_char(input logic [CH_W-1:0] c, input logic last);
        parse_result_t      r;
        logic [VALUE_W-1:0] mag;
        if (prs_phase != PH_STOP) begin
            if (c == CH_NUL) begin
                prs_phase = PH_STOP;
            end else if (prs_phase == PH_SIGN) begin
                if (sign_char(c)) begin
                    prs_neg   = (c == CH_MINUS);
                    prs_phase = PH_SPACE;
                end else if (blank_char(c)) begin
                    prs_phase = PH_SPACE;
                end else begin
                    take_digit(c);
                end
            end else if (prs_phase == PH_SPACE) begin
                if (!blank_char(c))
                    take_digit(c);
            end else begin
                take_digit(c);
            end
        end
        if (last) begin
            r.base_valid = alphabet_ok();
            mag          = prs_neg ? -prs_acc : prs_acc;
            r.value      = r.base_valid ? mag : '0;
            expected_parses.push_back(r);
            prs_phase = PH_SIGN;
            prs_acc   = '0;
            prs_neg   = 1'b0;
        end
    endtask

    // character driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle) begin
                next_char = pending_chars.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_char.ch;
                s_tlast  <= next_char.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    // result check and prediction of accepted characters
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken   <= 1'b0;
            prs_phase = PH_SIGN;
            prs_acc   = '0;
            prs_neg   = 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (expected_parses.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %0d base_valid %0b",
                             $time, $signed(m_tdata), m_tuser);
                    errors++;
                end else begin
                    due = expected_parses.pop_front();
                    if (m_tdata !== due.value) begin
                        $display("%0t: value mismatch, expected %0d, got %0d",
                                 $time, $signed(due.value), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== due.base_valid) begin
                        $display("%0t: base_valid mismatch, expected %0b, got %0b",
                                 $time, due.base_valid, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL text_to_integer_any_base");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // register write over the configuration port
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ALPHA_LOW:  alpha_lo_m  = val;
            REG_ALPHA_HIGH: alpha_hi_m  = val;
            REG_ALPHA_LEN:  alpha_len_m = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // pack alpha_syms into the two symbol words and set the length
    task automatic load_alphabet(input int len);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        lo = '0;
        hi = '0;
        for (int i = 0; i < alpha_syms.size() && i < 16; i++) begin
            if (i < 8)
                lo[i * 8 +: 8] = alpha_syms[i];
            else
                hi[(i - 8) * 8 +: 8] = alpha_syms[i];
        end
        write_reg(REG_ALPHA_LOW, lo);
        write_reg(REG_ALPHA_HIGH, hi);
        write_reg(REG_ALPHA_LEN, CFG_DATA_W'(len));
    endtask

    task automatic text_alphabet(input string t, input int len);
        alpha_syms.delete();
        for (int i = 0; i < t.len(); i++)
            alpha_syms.push_back(t[i]);
        load_alphabet(len);
    endtask

    function automatic logic [CH_W-1:0] rand_blank();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // random distinct non-sign symbols, sometimes with a blank or nul,
    // optionally spoiled by a repeat or a sign
    task automatic pick_alphabet(input int n, input logic flawed);
        logic [CH_W-1:0] c;
        logic            dup;
        int              j;
        alpha_syms.delete();
        while (alpha_syms.size() < n) begin
            c   = CH_W'($urandom_range(255));
            dup = sign_char(c);
            foreach (alpha_syms[k])
                if (alpha_syms[k] == c)
                    dup = 1'b1;
            if (!dup)
                alpha_syms.push_back(c);
        end
        if ($urandom_range(2) == 0)
            alpha_syms[$urandom_range(n - 1)] = $urandom_range(1) ? rand_blank() : CH_NUL;
        if (flawed) begin
            j = $urandom_range(n - 1);
            if ($urandom_range(1))
                alpha_syms[j] = alpha_syms[(j + 1) % n];
            else
                alpha_syms[j] = $urandom_range(1) ? CH_PLUS : CH_MINUS;
        end
    endtask

    function automatic logic [CH_W-1:0] rand_odd();
        case ($urandom_range(5))
            0:       return rand_blank();
            1:       return $urandom_range(1) ? CH_PLUS : CH_MINUS;
            2:       return CH_NUL;
            3:       return alpha_syms[$urandom_range(alpha_syms.size() - 1)];
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    task automatic push_char(input logic [CH_W-1:0] c, input logic last);
        char_item_t it;
        it.ch   = c;
        it.last = last;
        pending_chars.push_back(it);
        queued_count++;
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++)
            push_char(t[i], i == t.len() - 1);
    endtask

    // mostly sign, blanks, digits and an optional stopper; the rest is noise
    task automatic queue_string();
        logic [CH_W-1:0] s[$];
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(2))
                1:       s.push_back(CH_PLUS);
                2:       s.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(2)) s.push_back(rand_blank());
            repeat ($urandom_range(1, 10))
                s.push_back(alpha_syms[$urandom_range(alpha_syms.size() - 1)]);
            if ($urandom_range(2) == 0) begin
                s.push_back(rand_odd());
                repeat ($urandom_range(2)) s.push_back(rand_odd());
            end
        end else begin
            repeat ($urandom_range(1, 6)) s.push_back(rand_odd());
        end
        foreach (s[i])
            push_char(s[i], i == s.size() - 1);
    endtask

    // hold off until every character is taken and every result is back,
    // sampled at the rising edge where the driver outputs are settled
    task automatic wait_idle();
        while (pending_chars.size() != 0 || s_tvalid || expected_parses.size() != 0)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // reset, directed strings, then random chunks under changing alphabets
    initial begin : stimulus
        int first;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty alphabet right after reset
        push_char("5", 1'b1);
        wait_idle();

        text_alphabet("0123456789", 10);
        push_text("+7");
        push_text("-\t42");
        push_text("1 2");
        push_text("5x");
        push_char("3", 1'b0);
        push_char(CH_NUL, 1'b0);
        push_char("9", 1'b1);
        push_text("- -4");
        push_char(CH_NUL, 1'b1);
        push_char(8'hFF, 1'b1);
        push_char(CH_VT, 1'b0);
        push_char(CH_FF, 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b0);
        push_char("8", 1'b1);
        wait_idle();

        for (int k = 0; k < 12; k++) begin
            case (k / 4)
                0: begin
                    send_idle = 23;
                    recv_idle = 48;
                end
                1: begin
                    send_idle = 48;
                    recv_idle = 23;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (k)
                0:  text_alphabet("0123456789abcdef", 16);
                2:  text_alphabet("01", 2);
                3:  text_alphabet("0123456789", 1);
                5: begin
                    pick_alphabet($urandom_range(2, 16), 1'b1);
                    load_alphabet(alpha_syms.size());
                end
                6: begin
                    alpha_syms.delete();
                    repeat (16) alpha_syms.push_back(8'hFF);
                    load_alphabet(31);
                end
                8: begin
                    pick_alphabet(16, 1'b0);
                    load_alphabet(17);
                end
                10: begin
                    pick_alphabet(16, 1'b0);
                    load_alphabet(16);
                end
                11: text_alphabet("0123456789", 10);
                default: begin
                    pick_alphabet($urandom_range(2, 16), 1'b0);
                    load_alphabet(alpha_syms.size());
                end
            endcase
            first = queued_count;
            while (queued_count - first < CHUNK_CHARS)
                queue_string();
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (expected_parses.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_parses.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS text_to_integer_any_base");
        end else begin
            $display("FAIL text_to_integer_any_base");
        end
        $finish;
    end

endmodule
